// File: src/multiplexed_seven_segment_scanner_macros.svh
// Assertion macros shared by the scanner RTL.
// Included by the modules that carry checks; relies on signals named clock and reset.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_SCANNER_MACROS_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// cond holds in the same cycle as trig
`define MSS_ASSERT_SAME(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("scanner check failed");
// cond holds in the cycle after trig
`define MSS_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("scanner check failed");
`else
`define MSS_ASSERT_SAME(label, trig, cond)
`define MSS_ASSERT_NEXT(label, trig, cond)
`endif
`endif

// File: src/mss_pkg.sv
// Shared types, constants and lookup functions for the seven-segment scanner.
// No dependencies; used by the interfaces and every module.
package mss_pkg;

   localparam int NUMBER_W    = 14;
   localparam int LIMIT_W     = 14;
   localparam int LEN_W       = 3;
   localparam int DIGIT_COUNT = 4;
   localparam int LIST_SIZE   = 5;
   localparam int POS_W       = 2;
   localparam int IDX_W       = 3;
   localparam int SEG_W       = 7;
   localparam int BCD_W       = 4;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;

   // register indexes (byte address / 4)
   localparam logic [IDX_W-1:0] REG_NUMBER_A    = 3'd0;
   localparam logic [IDX_W-1:0] REG_NUMBER_B    = 3'd1;
   localparam logic [IDX_W-1:0] REG_NUMBER_C    = 3'd2;
   localparam logic [IDX_W-1:0] REG_NUMBER_D    = 3'd3;
   localparam logic [IDX_W-1:0] REG_NUMBER_E    = 3'd4;
   localparam logic [IDX_W-1:0] REG_DWELL_LIMIT = 3'd5;
   localparam logic [IDX_W-1:0] REG_LIST_LENGTH = 3'd6;

   localparam logic [NUMBER_W-1:0] RESET_NUMBER_A = 14'd1234;
   localparam logic [NUMBER_W-1:0] RESET_NUMBER_B = 14'd9876;
   localparam logic [NUMBER_W-1:0] RESET_NUMBER_C = 14'd537;
   localparam logic [NUMBER_W-1:0] RESET_NUMBER_D = 14'd6329;
   localparam logic [NUMBER_W-1:0] RESET_NUMBER_E = 14'd7948;
   localparam logic [LIMIT_W-1:0]  RESET_DWELL    = 14'd9800;
   localparam logic [LEN_W-1:0]    RESET_LENGTH   = 3'd5;

   // floor(n / 10^k) = (n * m_k) >> 24 is exact for every 14-bit n
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP_ONE      = 25'd16777216;
   localparam logic [RECIP_W-1:0] RECIP_TEN      = 25'd1677722;
   localparam logic [RECIP_W-1:0] RECIP_HUNDRED  = 25'd167773;
   localparam logic [RECIP_W-1:0] RECIP_THOUSAND = 25'd16778;

   // floor(q / 10) = (q * 26215) >> 18 for every 14-bit q
   localparam int TEN_RECIP_W = 15;
   localparam int TEN_SHIFT   = 18;
   localparam int TEN_QUOT_W  = 11;
   localparam logic [TEN_RECIP_W-1:0] TEN_RECIP = 15'd26215;

   typedef struct packed {
      logic [LIST_SIZE-1:0][NUMBER_W-1:0] numbers;
      logic [LIMIT_W-1:0]                 dwell_limit;
      logic [LEN_W-1:0]                   list_length;
   } cfg_type;

   function automatic logic [RECIP_W-1:0] place_recip(input logic [POS_W-1:0] pos);
      logic [RECIP_W-1:0] m;
      case (pos)
         2'd0:    m = RECIP_ONE;
         2'd1:    m = RECIP_TEN;
         2'd2:    m = RECIP_HUNDRED;
         2'd3:    m = RECIP_THOUSAND;
         default: m = RECIP_ONE;
      endcase
      return m;
   endfunction

   // common-cathode pattern, bit 0 = segment a
   function automatic logic [SEG_W-1:0] seg_pattern(input logic [BCD_W-1:0] digit);
      logic [SEG_W-1:0] s;
      case (digit)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h6F;
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

// File: src/mss_interfaces.sv
// Valid/ready channel interfaces for the scanner's tick and result words.
// Depends on mss_pkg for field widths.
interface mss_req_if;
   logic valid;
   logic ready;
   logic tick_pulse;

   modport source (output valid, output tick_pulse, input ready);
   modport sink (input valid, input tick_pulse, output ready);
endinterface

interface mss_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mss_pkg::SEG_W-1:0]       segments;
   logic [mss_pkg::DIGIT_COUNT-1:0] digit_select;
   logic [mss_pkg::IDX_W-1:0]       shown_index;

   modport source (output valid, output segments, output digit_select, output shown_index,
                   input ready);
   modport sink (input valid, input segments, input digit_select, input shown_index,
                 output ready);
endinterface

// File: src/mss_csr.sv
// APB-style configuration registers: display list, dwell limit and list length.
// Depends on mss_pkg.
module mss_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mss_pkg::ADDR_W-1:0]   paddr,
   input  logic [mss_pkg::DATA_W-1:0]   pwdata,
   output logic [mss_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output mss_pkg::cfg_type             cfg
);

   logic [mss_pkg::IDX_W-1:0] reg_idx;
   logic                      wr_en;
   mss_pkg::cfg_type          cfg_ff;
   mss_pkg::cfg_type          cfg_in;

   assign reg_idx = paddr[mss_pkg::ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            mss_pkg::REG_NUMBER_A:    cfg_in.numbers[0] = pwdata[mss_pkg::NUMBER_W-1:0];
            mss_pkg::REG_NUMBER_B:    cfg_in.numbers[1] = pwdata[mss_pkg::NUMBER_W-1:0];
            mss_pkg::REG_NUMBER_C:    cfg_in.numbers[2] = pwdata[mss_pkg::NUMBER_W-1:0];
            mss_pkg::REG_NUMBER_D:    cfg_in.numbers[3] = pwdata[mss_pkg::NUMBER_W-1:0];
            mss_pkg::REG_NUMBER_E:    cfg_in.numbers[4] = pwdata[mss_pkg::NUMBER_W-1:0];
            mss_pkg::REG_DWELL_LIMIT: cfg_in.dwell_limit = pwdata[mss_pkg::LIMIT_W-1:0];
            mss_pkg::REG_LIST_LENGTH: cfg_in.list_length = pwdata[mss_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.numbers[0]  <= mss_pkg::RESET_NUMBER_A;
         cfg_ff.numbers[1]  <= mss_pkg::RESET_NUMBER_B;
         cfg_ff.numbers[2]  <= mss_pkg::RESET_NUMBER_C;
         cfg_ff.numbers[3]  <= mss_pkg::RESET_NUMBER_D;
         cfg_ff.numbers[4]  <= mss_pkg::RESET_NUMBER_E;
         cfg_ff.dwell_limit <= mss_pkg::RESET_DWELL;
         cfg_ff.list_length <= mss_pkg::RESET_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         mss_pkg::REG_NUMBER_A:    prdata = mss_pkg::DATA_W'(cfg_ff.numbers[0]);
         mss_pkg::REG_NUMBER_B:    prdata = mss_pkg::DATA_W'(cfg_ff.numbers[1]);
         mss_pkg::REG_NUMBER_C:    prdata = mss_pkg::DATA_W'(cfg_ff.numbers[2]);
         mss_pkg::REG_NUMBER_D:    prdata = mss_pkg::DATA_W'(cfg_ff.numbers[3]);
         mss_pkg::REG_NUMBER_E:    prdata = mss_pkg::DATA_W'(cfg_ff.numbers[4]);
         mss_pkg::REG_DWELL_LIMIT: prdata = mss_pkg::DATA_W'(cfg_ff.dwell_limit);
         mss_pkg::REG_LIST_LENGTH: prdata = mss_pkg::DATA_W'(cfg_ff.list_length);
         default:                  prdata = '0;
      endcase
   end

endmodule

// File: src/mss_digit.sv
// Second datapath stage: quotient mod 10 and segment pattern lookup.
// Depends on mss_pkg.
module mss_digit (
   input  logic [mss_pkg::NUMBER_W-1:0] quot,
   output logic [mss_pkg::SEG_W-1:0]    segments
);

   localparam int PROD_W = mss_pkg::NUMBER_W + mss_pkg::TEN_RECIP_W;

   logic [PROD_W-1:0]              prod;
   logic [mss_pkg::TEN_QUOT_W-1:0] tens;
   logic [mss_pkg::NUMBER_W-1:0]   tens_x10;
   logic [mss_pkg::NUMBER_W-1:0]   rem;

   assign prod = PROD_W'(quot) * PROD_W'(mss_pkg::TEN_RECIP);
   assign tens = prod[mss_pkg::TEN_SHIFT +: mss_pkg::TEN_QUOT_W];
   // tens * 10 as 8x + 2x
   assign tens_x10 = mss_pkg::NUMBER_W'({tens, 3'b000}) + mss_pkg::NUMBER_W'({tens, 1'b0});
   assign rem      = quot - tens_x10;
   assign segments = mss_pkg::seg_pattern(rem[mss_pkg::BCD_W-1:0]);

endmodule

// File: src/multiplexed_seven_segment_scanner.sv
// Multiplexed seven-segment scanner: takes one tick word per cycle while the output
// side keeps up and returns one result word for each. Stage one selects the shown
// number and divides it by the place value of the current digit (a 14x25 multiply by
// a reciprocal); stage two takes that quotient mod 10 and looks up the common-cathode
// pattern into the output register. Scan position, dwell counter and list position
// update at the edge the tick is taken, so a new word can be taken every cycle while
// the output side keeps up. A word with tick_pulse low returns blank segments, no
// digit select and the current list index, and changes nothing.
// Depends on mss_pkg, mss_interfaces, mss_csr, mss_digit and the macros header.
`include "multiplexed_seven_segment_scanner_macros.svh"

module multiplexed_seven_segment_scanner (
   input  logic                         clock,
   input  logic                         reset,
   mss_req_if.sink                      req_port,
   mss_rsp_if.source                    rsp_port,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mss_pkg::ADDR_W-1:0]   paddr,
   input  logic [mss_pkg::DATA_W-1:0]   pwdata,
   output logic [mss_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);

   localparam int PROD_W = mss_pkg::NUMBER_W + mss_pkg::RECIP_W;

   mss_pkg::cfg_type cfg;

   // scan state
   logic [mss_pkg::POS_W-1:0]   scan_ff, scan_in;
   logic [mss_pkg::LIMIT_W-1:0] dwell_ff, dwell_in;
   logic [mss_pkg::IDX_W-1:0]   list_pos_ff, list_pos_in;

   // stage one
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_tick_ff;
   logic [mss_pkg::POS_W-1:0]     s1_pos_ff;
   logic [mss_pkg::IDX_W-1:0]     s1_index_ff;
   logic [mss_pkg::NUMBER_W-1:0]  s1_quot_ff, s1_quot_in;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mss_pkg::SEG_W-1:0]       rsp_seg_ff, rsp_seg_in;
   logic [mss_pkg::DIGIT_COUNT-1:0] rsp_sel_ff, rsp_sel_in;
   logic [mss_pkg::IDX_W-1:0]       rsp_index_ff;

   logic                          out_load;
   logic                          in_ready;
   logic                          accept;
   logic                          tick_take;
   logic [mss_pkg::NUMBER_W-1:0]  num_sel;
   logic [PROD_W-1:0]             prod;
   logic [mss_pkg::SEG_W-1:0]     digit_seg;
   logic [mss_pkg::IDX_W-1:0]     eff_len;
   logic [mss_pkg::IDX_W-1:0]     list_next;

   mss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mss_digit u_digit (
      .quot     (s1_quot_ff),
      .segments (digit_seg)
   );

   // pipeline flow: the output register frees when its word is taken
   assign out_load  = !rsp_valid_ff || rsp_port.ready;
   assign in_ready  = !s1_valid_ff || out_load;
   assign accept    = req_port.valid && in_ready;
   assign tick_take = accept && req_port.tick_pulse;

   assign req_port.ready        = in_ready;
   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.segments     = rsp_seg_ff;
   assign rsp_port.digit_select = rsp_sel_ff;
   assign rsp_port.shown_index  = rsp_index_ff;

   always_comb begin
      case (list_pos_ff)
         3'd0:    num_sel = cfg.numbers[0];
         3'd1:    num_sel = cfg.numbers[1];
         3'd2:    num_sel = cfg.numbers[2];
         3'd3:    num_sel = cfg.numbers[3];
         3'd4:    num_sel = cfg.numbers[4];
         default: num_sel = '0;
      endcase
   end

   assign prod       = PROD_W'(num_sel) * PROD_W'(mss_pkg::place_recip(scan_ff));
   assign s1_quot_in = prod[mss_pkg::RECIP_SHIFT +: mss_pkg::NUMBER_W];

   // zero length acts as one, anything above the list size as the list size
   always_comb begin
      if (cfg.list_length == '0) begin
         eff_len = mss_pkg::IDX_W'(1);
      end else if (cfg.list_length > mss_pkg::IDX_W'(mss_pkg::LIST_SIZE)) begin
         eff_len = mss_pkg::IDX_W'(mss_pkg::LIST_SIZE);
      end else begin
         eff_len = cfg.list_length;
      end
   end

   always_comb begin
      list_next = list_pos_ff + mss_pkg::IDX_W'(1);
      if (list_next >= eff_len) begin
         list_next = '0;
      end
   end

   always_comb begin
      scan_in     = scan_ff;
      dwell_in    = dwell_ff;
      list_pos_in = list_pos_ff;
      if (tick_take) begin
         if (scan_ff == mss_pkg::POS_W'(mss_pkg::DIGIT_COUNT - 1)) begin
            scan_in = '0;
         end else begin
            scan_in = scan_ff + mss_pkg::POS_W'(1);
         end
         if (dwell_ff < cfg.dwell_limit) begin
            dwell_in = dwell_ff + mss_pkg::LIMIT_W'(1);
         end else begin
            dwell_in    = '0;
            list_pos_in = list_next;
         end
      end
   end

   assign s1_valid_in  = in_ready ? accept : s1_valid_ff;
   assign rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;
   assign rsp_seg_in   = s1_tick_ff ? digit_seg : '0;
   assign rsp_sel_in   = s1_tick_ff ? (mss_pkg::DIGIT_COUNT'(1) << s1_pos_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         dwell_ff     <= '0;
         list_pos_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         dwell_ff     <= dwell_in;
         list_pos_ff  <= list_pos_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tick_ff  <= req_port.tick_pulse;
         s1_pos_ff   <= scan_ff;
         s1_index_ff <= list_pos_ff;
         s1_quot_ff  <= s1_quot_in;
      end
      if (out_load && s1_valid_ff) begin
         rsp_seg_ff   <= rsp_seg_in;
         rsp_sel_ff   <= rsp_sel_in;
         rsp_index_ff <= s1_index_ff;
      end
   end

   `MSS_ASSERT_SAME(a_sel_onehot, rsp_valid_ff, $onehot0(rsp_sel_ff))
   `MSS_ASSERT_SAME(a_blank_no_sel, rsp_valid_ff && rsp_sel_ff == '0, rsp_seg_ff == '0)
   `MSS_ASSERT_SAME(a_list_range, 1'b1, list_pos_ff < mss_pkg::IDX_W'(mss_pkg::LIST_SIZE))
   `MSS_ASSERT_NEXT(a_idle_word_holds, accept && !req_port.tick_pulse,
                    $stable(scan_ff) && $stable(dwell_ff) && $stable(list_pos_ff))
   `MSS_ASSERT_NEXT(a_dwell_step, tick_take && dwell_ff < cfg.dwell_limit,
                    dwell_ff == $past(dwell_ff) + mss_pkg::LIMIT_W'(1))

endmodule

// File: tb/multiplexed_seven_segment_scanner_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the seven-segment scanner: directed table, then random tick words.
// Depends on mss_pkg, mss_interfaces and the scanner RTL; holds its own scan/dwell predictor.
module multiplexed_seven_segment_scanner_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_WORDS = 36;
   localparam int PLAN_ROWS   = 30;

   localparam logic [mss_pkg::SEG_W-1:0] GLYPH [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };
   localparam int PLACE_VALUE [4] = '{1, 10, 100, 1000};

   typedef struct packed {
      logic [mss_pkg::SEG_W-1:0]       segments;
      logic [mss_pkg::DIGIT_COUNT-1:0] digit_select;
      logic [mss_pkg::IDX_W-1:0]       shown_index;
   } scan_word_type;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [mss_pkg::IDX_W-1:0]  reg_idx;
      logic [mss_pkg::DATA_W-1:0] value;
      logic                       tick;
      logic                       typed;
      scan_word_type              want;
   } plan_row_type;

   // typed expectations only after reset and at the extremes
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b0, 1'b1, '{7'h00, 4'h0, 3'd0}},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b1, '{7'h66, 4'h1, 3'd0}},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b1, '{7'h4F, 4'h2, 3'd0}},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b1, '{7'h5B, 4'h4, 3'd0}},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b1, '{7'h06, 4'h8, 3'd0}},
      '{ROW_WRITE, mss_pkg::REG_DWELL_LIMIT, 32'd0,     1'b0, 1'b0, '0},
      '{ROW_WRITE, mss_pkg::REG_NUMBER_A,    32'd16383, 1'b0, 1'b0, '0},
      '{ROW_WRITE, mss_pkg::REG_NUMBER_B,    32'd0,     1'b0, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b1, '{7'h4F, 4'h1, 3'd0}},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      // list position now past a list of two
      '{ROW_WRITE, mss_pkg::REG_LIST_LENGTH, 32'd2,     1'b0, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      '{ROW_WRITE, mss_pkg::REG_LIST_LENGTH, 32'd0,     1'b0, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b0, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      '{ROW_WRITE, mss_pkg::REG_LIST_LENGTH, 32'd7,     1'b0, 1'b0, '0},
      '{ROW_WRITE, mss_pkg::REG_NUMBER_E,    32'd16383, 1'b0, 1'b0, '0},
      '{ROW_WRITE, mss_pkg::REG_DWELL_LIMIT, 32'd16383, 1'b0, 1'b0, '0},
      '{ROW_WRITE, mss_pkg::REG_NUMBER_C,    32'd9999,  1'b0, 1'b0, '0},
      '{ROW_WRITE, mss_pkg::REG_NUMBER_D,    32'hFFFFFFFF, 1'b0, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b1, 1'b0, '0},
      '{ROW_TICK,  mss_pkg::REG_NUMBER_A,    32'd0,     1'b0, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [mss_pkg::ADDR_W-1:0] paddr = '0;
   logic [mss_pkg::DATA_W-1:0] pwdata = '0;
   logic [mss_pkg::DATA_W-1:0] prdata;
   logic pready;

   mss_req_if req_if();
   mss_rsp_if rsp_if();

   multiplexed_seven_segment_scanner dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor state and its copy of the registers
   logic [mss_pkg::NUMBER_W-1:0] list_numbers [mss_pkg::LIST_SIZE];
   logic [mss_pkg::LIMIT_W-1:0]  advance_limit;
   logic [mss_pkg::LEN_W-1:0]    span_setting;
   logic [mss_pkg::POS_W-1:0]    scan_pos;
   logic [mss_pkg::LIMIT_W-1:0]  dwell_ticks;
   logic [mss_pkg::IDX_W-1:0]    list_pos;

   scan_word_type pending_words [$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  calm = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void predict_scan_word(input logic tick, output scan_word_type w);
      int num;
      int digit;
      int span;
      int nxt;
      if (!tick) begin
         w = '{'0, '0, list_pos};
         return;
      end
      num   = list_numbers[list_pos % mss_pkg::LIST_SIZE];
      digit = (num / PLACE_VALUE[scan_pos]) % 10;
      w = '{GLYPH[digit], 4'b0001 << scan_pos, list_pos};
      scan_pos = scan_pos + 1'b1;
      if (dwell_ticks < advance_limit) begin
         dwell_ticks = dwell_ticks + 1'b1;
      end else begin
         dwell_ticks = '0;
         span = (span_setting == 0) ? 1 :
                (span_setting > mss_pkg::LIST_SIZE) ? mss_pkg::LIST_SIZE : span_setting;
         nxt  = list_pos + 1;
         if (nxt >= span) nxt = 0;
         list_pos = nxt[mss_pkg::IDX_W-1:0];
      end
   endfunction

   // hold valid low and let every outstanding word come back
   task automatic settle_pipeline();
      req_if.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [mss_pkg::IDX_W-1:0] idx,
                                 input logic [mss_pkg::DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         mss_pkg::REG_NUMBER_A, mss_pkg::REG_NUMBER_B, mss_pkg::REG_NUMBER_C,
         mss_pkg::REG_NUMBER_D, mss_pkg::REG_NUMBER_E:
            list_numbers[idx] = value[mss_pkg::NUMBER_W-1:0];
         mss_pkg::REG_DWELL_LIMIT: advance_limit = value[mss_pkg::LIMIT_W-1:0];
         mss_pkg::REG_LIST_LENGTH: span_setting = value[mss_pkg::LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_tick(input logic tick, input logic typed,
                            input scan_word_type typed_word);
      scan_word_type w;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.tick_pulse <= tick;
      do @(posedge clock); while (!req_if.ready);
      predict_scan_word(tick, w);
      pending_words.push_back(typed ? typed_word : w);
   endtask

   // result side back-pressure in bursts
   initial begin : rsp_stall
      int hold;
      hold = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_if.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 11) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected word: segments %h digit_select %h shown_index %0d",
                   rsp_if.segments, rsp_if.digit_select, rsp_if.shown_index);
            mismatch_count++;
         end else begin
            if (rsp_if.segments !== pending_words[0].segments) begin
               $error("segments: expected %h, actual %h",
                      pending_words[0].segments, rsp_if.segments);
               mismatch_count++;
            end
            if (rsp_if.digit_select !== pending_words[0].digit_select) begin
               $error("digit_select: expected %h, actual %h",
                      pending_words[0].digit_select, rsp_if.digit_select);
               mismatch_count++;
            end
            if (rsp_if.shown_index !== pending_words[0].shown_index) begin
               $error("shown_index: expected %0d, actual %0d",
                      pending_words[0].shown_index, rsp_if.shown_index);
               mismatch_count++;
            end
            void'(pending_words.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL multiplexed_seven_segment_scanner");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned roll;
      int unsigned v;
      logic [mss_pkg::DATA_W-1:0] spare;
      req_if.valid      <= 1'b0;
      req_if.tick_pulse <= 1'b0;
      list_numbers  = '{mss_pkg::RESET_NUMBER_A, mss_pkg::RESET_NUMBER_B,
                        mss_pkg::RESET_NUMBER_C, mss_pkg::RESET_NUMBER_D,
                        mss_pkg::RESET_NUMBER_E};
      advance_limit = mss_pkg::RESET_DWELL;
      span_setting  = mss_pkg::RESET_LENGTH;
      scan_pos      = '0;
      dwell_ticks   = '0;
      list_pos      = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_PLAN[i]) begin
         if (DIRECTED_PLAN[i].kind == ROW_WRITE) begin
            settle_pipeline();
            write_register(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].value);
         end else begin
            send_tick(DIRECTED_PLAN[i].tick, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_pipeline();
         calm = (phase >= PHASE_COUNT - 2);
         // phase 0 minimum numbers and dwell limit with a list length of one, phase 1 all maximum, then random settings
         for (int r = 0; r < mss_pkg::LIST_SIZE; r++) begin
            roll = $urandom_range(0, 9);
            v = (phase == 0) ? 0 : (phase == 1) ? 16383 :
                (roll < 7) ? $urandom_range(0, 9999) : (roll == 7) ? 9999 :
                (roll == 8) ? 16383 : $urandom_range(0, 16383);
            spare = ($urandom_range(0, 3) == 0) ? ($urandom() << mss_pkg::NUMBER_W) : '0;
            if (phase < 2 || $urandom_range(0, 1) == 1)
               write_register(mss_pkg::IDX_W'(mss_pkg::REG_NUMBER_A + r), spare | v);
         end
         roll = $urandom_range(0, 19);
         v = (phase == 0) ? 0 : (phase == 1) ? 16383 :
             (roll < 12) ? $urandom_range(0, 6) : (roll < 17) ? $urandom_range(0, 40) :
             $urandom_range(0, 16383);
         spare = ($urandom_range(0, 3) == 0) ? ($urandom() << mss_pkg::LIMIT_W) : '0;
         write_register(mss_pkg::REG_DWELL_LIMIT, spare | v);
         v = (phase == 0) ? 1 : (phase == 1) ? 7 : $urandom_range(0, 7);
         spare = ($urandom_range(0, 3) == 0) ? ($urandom() << mss_pkg::LEN_W) : '0;
         write_register(mss_pkg::REG_LIST_LENGTH, spare | v);

         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 59) == 0) settle_pipeline();
            send_tick($urandom_range(0, 4) != 0, 1'b0, '0);
         end
      end

      settle_pipeline();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_words.size() == 0) begin
         $display("PASS multiplexed_seven_segment_scanner");
      end else begin
         $display("FAIL multiplexed_seven_segment_scanner");
      end
      $finish;
   end

endmodule
